FILE: rtl/dith_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the error-diffusion dither block.
// No dependencies; dith_ctrl, dith_core and the top level refer to it by scoped names.
package dith_pkg;

    // Pixel level and line-width register widths
    localparam int LEVEL_W     = 8;
    localparam int CFG_W       = 11;
    localparam int WIDTH_RESET = 640;

    // Every diffusion share is a multiple of 1/16
    localparam int SHARE_SHIFT = 4;

    // Per-pixel control that travels from the column tracker to the error core
    typedef struct packed {
        logic frame_start;  // beat opens a new image
        logic last;         // beat closes its line
        logic mask;         // line buffer reads as zero (first line of the image)
    } dith_ctl_t;

endpackage

FILE: rtl/dith_line_mem.sv
`timescale 1ns / 1ps
// Line buffer: one write port, one read port, read data registered.
// No dependencies.
module dith_line_mem #(
    parameter int DEPTH = 1024,
    parameter int DW    = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read-before-write: a same-edge write is not seen here
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/dith_ctrl.sv
`timescale 1ns / 1ps
// Column and line tracking plus the line_width register.
// Depends on dith_pkg.
module dith_ctrl #(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dith_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            accept,
    input  logic                            frame_start,
    output logic [$clog2(MAX_LINE_WIDTH)-1:0] col,
    output dith_pkg::dith_ctl_t             ctl
);

    localparam int COLW = $clog2(MAX_LINE_WIDTH);
    localparam int CW   = COLW + 1;
    localparam int WCMP = (CW > dith_pkg::CFG_W) ? CW : dith_pkg::CFG_W;
    localparam logic [WCMP-1:0] MAX_W = WCMP'(MAX_LINE_WIDTH);

    logic [dith_pkg::CFG_W-1:0] line_width_reg;
    logic [COLW-1:0]            col_reg;
    logic [COLW-1:0]            col_next;
    logic                       first_line_reg;
    logic                       first_line_next;
    logic [WCMP-1:0]            lw_ext;
    logic [WCMP-1:0]            w_eff;
    logic [WCMP-1:0]            col_inc;

    always_comb
    begin
        lw_ext = WCMP'(line_width_reg);
        // Clamp: zero acts as one, oversize acts as the buffer depth
        if (lw_ext == '0)
        begin
            w_eff = WCMP'(1);
        end
        else if (lw_ext > MAX_W)
        begin
            w_eff = MAX_W;
        end
        else
        begin
            w_eff = lw_ext;
        end

        col     = frame_start ? '0 : col_reg;
        col_inc = WCMP'(col) + WCMP'(1);

        ctl.frame_start = frame_start;
        ctl.last        = (col_inc >= w_eff);
        ctl.mask        = frame_start | first_line_reg;

        col_next        = col_reg;
        first_line_next = first_line_reg;
        if (accept)
        begin
            col_next        = ctl.last ? '0 : col_inc[COLW-1:0];
            first_line_next = ctl.last ? 1'b0 : ctl.mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= dith_pkg::CFG_W'(dith_pkg::WIDTH_RESET);
            col_reg        <= '0;
            first_line_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                line_width_reg <= cfg_wdata;
            end
            col_reg        <= col_next;
            first_line_reg <= first_line_next;
        end
    end

endmodule

FILE: rtl/dith_core.sv
`timescale 1ns / 1ps
// Error core: sum, threshold, diffusion shares, line-buffer writeback and
// forwarding, and the output register. Depends on dith_pkg.
module dith_core #(
    parameter int MAX_LINE_WIDTH = 1024,
    parameter int FRACTION_BITS  = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [$clog2(MAX_LINE_WIDTH)-1:0] in_col,
    input  logic [dith_pkg::LEVEL_W-1:0]      in_level,
    input  dith_pkg::dith_ctl_t               in_ctl,
    output logic                              in_stall,
    output logic                              mem_we,
    output logic [$clog2(MAX_LINE_WIDTH)-1:0] mem_waddr,
    output logic [FRACTION_BITS+11:0]         mem_wdata,
    input  logic [FRACTION_BITS+11:0]         mem_rdata,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic                              pixel_on
);

    localparam int AW   = FRACTION_BITS + 12;
    localparam int SW   = AW + 5;
    localparam int COLW = $clog2(MAX_LINE_WIDTH);
    localparam int ZPAD = SW - dith_pkg::LEVEL_W - FRACTION_BITS;
    localparam logic signed [SW-1:0] ACC_MAX_S = SW'((2 ** (AW - 1)) - 1);
    localparam logic signed [SW-1:0] ACC_MIN_S = SW'(-(2 ** (AW - 1)));
    localparam logic signed [AW-1:0] HALF_S    = AW'(255 * (2 ** (FRACTION_BITS - 1)));
    localparam logic signed [SW-1:0] FULL_S    = SW'(255 * (2 ** FRACTION_BITS));

    function automatic logic signed [AW-1:0] sat_acc(input logic signed [SW-1:0] v);
        logic signed [AW-1:0] r;
        if (v > ACC_MAX_S)
        begin
            r = ACC_MAX_S[AW-1:0];
        end
        else if (v < ACC_MIN_S)
        begin
            r = ACC_MIN_S[AW-1:0];
        end
        else
        begin
            r = v[AW-1:0];
        end
        return r;
    endfunction

    // Stage 1 (line-buffer data arrives here)
    logic                          s1_valid_reg, s1_valid_next;
    logic [COLW-1:0]               s1_col_reg;
    logic [dith_pkg::LEVEL_W-1:0]  s1_level_reg;
    dith_pkg::dith_ctl_t           s1_ctl_reg;
    logic                          s1_adv;
    logic                          s1_wr_en;

    // Error state
    logic signed [AW-1:0] right_reg, right_next;
    logic signed [AW-1:0] pend_reg,  pend_next;
    logic signed [AW-1:0] diag_reg,  diag_next;

    // Deferred write of the last column of a line
    logic                 tail_valid_reg, tail_valid_next;
    logic [COLW-1:0]      tail_addr_reg;
    logic signed [AW-1:0] tail_data_reg;

    // Forwarding of writes that the registered read missed
    logic                 patch_valid_reg, patch_valid_next;
    logic signed [AW-1:0] patch_data_reg;
    logic                 patch_hit;

    logic                 out_valid_reg, out_valid_next;
    logic                 pixel_on_reg;

    logic signed [AW-1:0] r_in, pend_in, diag_in, above;
    logic signed [SW-1:0] lvl_fx, sum_raw, err;
    logic signed [SW-1:0] p7, p5, p3, sh7, sh5, sh3, sh1;
    logic signed [AW-1:0] sum, bl_val, pend_new;
    logic                 white;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign s1_wr_en = s1_adv && (s1_col_reg != '0);

    always_comb
    begin
        // Frame start drops all carried error
        r_in    = s1_ctl_reg.frame_start ? '0 : right_reg;
        pend_in = s1_ctl_reg.frame_start ? '0 : pend_reg;
        diag_in = s1_ctl_reg.frame_start ? '0 : diag_reg;

        if (s1_ctl_reg.mask)
        begin
            above = '0;
        end
        else if (tail_valid_reg && (tail_addr_reg == s1_col_reg))
        begin
            // Line-end write lands while the next beat already waits on it
            above = tail_data_reg;
        end
        else if (patch_valid_reg)
        begin
            above = patch_data_reg;
        end
        else
        begin
            above = $signed(mem_rdata);
        end

        lvl_fx  = $signed({{ZPAD{1'b0}}, s1_level_reg, {FRACTION_BITS{1'b0}}});
        sum_raw = lvl_fx + SW'(above) + SW'(r_in);
        sum     = sat_acc(sum_raw);
        white   = (sum > HALF_S);
        err     = white ? (SW'(sum) - FULL_S) : SW'(sum);

        // e*7, e*5, e*3 by shift-add; arithmetic shift gives the floor
        p7  = (err <<< 3) - err;
        p5  = (err <<< 2) + err;
        p3  = (err <<< 1) + err;
        sh7 = p7 >>> dith_pkg::SHARE_SHIFT;
        sh5 = p5 >>> dith_pkg::SHARE_SHIFT;
        sh3 = p3 >>> dith_pkg::SHARE_SHIFT;
        sh1 = err >>> dith_pkg::SHARE_SHIFT;

        bl_val   = sat_acc(SW'(pend_in) + sh3);
        pend_new = sat_acc(SW'(diag_in) + sh5);

        right_next = right_reg;
        pend_next  = pend_reg;
        diag_next  = diag_reg;
        if (s1_adv)
        begin
            right_next = s1_ctl_reg.last ? '0 : sat_acc(sh7);
            pend_next  = s1_ctl_reg.last ? '0 : pend_new;
            diag_next  = s1_ctl_reg.last ? '0 : sh1[AW-1:0];
        end

        tail_valid_next = s1_adv && s1_ctl_reg.last;

        // One write port: the tail slot never collides with a below-left write,
        // since the beat after a line end sits in column zero
        mem_we = tail_valid_reg || s1_wr_en;
        if (tail_valid_reg)
        begin
            mem_waddr = tail_addr_reg;
            mem_wdata = tail_data_reg;
        end
        else
        begin
            mem_waddr = s1_col_reg - COLW'(1);
            mem_wdata = bl_val;
        end

        // Catch writes that land on the column read for the beat entering or
        // waiting in stage 1; keep only a matching write
        patch_hit = mem_we && (mem_waddr == (accept ? in_col : s1_col_reg));
        if (accept)
        begin
            patch_valid_next = patch_hit;
        end
        else
        begin
            patch_valid_next = patch_valid_reg || patch_hit;
        end

        s1_valid_next = accept || (s1_valid_reg && !s1_adv);

        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            right_reg       <= '0;
            pend_reg        <= '0;
            diag_reg        <= '0;
            tail_valid_reg  <= 1'b0;
            patch_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            right_reg       <= right_next;
            pend_reg        <= pend_next;
            diag_reg        <= diag_next;
            tail_valid_reg  <= tail_valid_next;
            patch_valid_reg <= patch_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg   <= in_col;
            s1_level_reg <= in_level;
            s1_ctl_reg   <= in_ctl;
        end
        if (s1_adv)
        begin
            tail_addr_reg <= s1_col_reg;
            tail_data_reg <= pend_new;
            pixel_on_reg  <= white;
        end
        if (patch_hit)
        begin
            patch_data_reg <= mem_wdata;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_on  = pixel_on_reg;

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(tail_valid_reg && s1_wr_en))
        else $error("tail write collides with below-left write");

    a_tail_col0: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_valid_reg && s1_valid_reg) |-> (s1_col_reg == '0))
        else $error("beat after line end not in column zero");

    a_tail_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_ctl_reg.last) |=> tail_valid_reg)
        else $error("line end left no tail write");

endmodule

FILE: rtl/error_diffusion_dither.sv
`timescale 1ns / 1ps
// Error-diffusion (Floyd-Steinberg) dither, top level.
// Depends on dith_pkg, dith_ctrl, dith_core and dith_line_mem.
//
// Usage:
//   Input channel: in_valid / in_stall with pixel_level and frame_start. A beat
//   moves on a rising edge with in_valid high and in_stall low. Pixels come in
//   raster order; frame_start marks the first pixel of an image and masks the
//   line buffer for that image's first line.
//   Output channel: out_valid / out_stall with pixel_on, one beat per input beat,
//   in order.
//   Configuration: cfg_we / cfg_wdata write line_width (pixels per line); write
//   it only while no pixel is in flight. Zero acts as one, values above
//   MAX_LINE_WIDTH act as MAX_LINE_WIDTH.
//   Throughput: one pixel per clock while out_stall is low. The right-neighbor
//   error loop closes through right_reg, and the line buffer takes one read and
//   one write per clock; a line end adds a second write, issued in the following
//   cycle while column zero needs none.
//   Path: an accepted pixel is registered into stage 1 with its line-buffer read,
//   then its result is registered in the output register that drives pixel_on.
//   Reset: line_width returns to 640 and the first line reads zero error; the
//   line buffer is never swept, so there is no clearing pass.
//   Stall: when out_stall holds a result, one more pixel is taken into the error
//   core, then in_stall rises until the output drains.
module error_diffusion_dither #(
    parameter int MAX_LINE_WIDTH = 1024,
    parameter int FRACTION_BITS  = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dith_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [dith_pkg::LEVEL_W-1:0]     pixel_level,
    input  logic                             frame_start,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             pixel_on
);

    localparam int COLW = $clog2(MAX_LINE_WIDTH);
    localparam int AW   = FRACTION_BITS + 12;

    logic                 accept;
    logic [COLW-1:0]      col;
    dith_pkg::dith_ctl_t  ctl;
    logic                 mem_we;
    logic [COLW-1:0]      mem_waddr;
    logic [AW-1:0]        mem_wdata;
    logic [AW-1:0]        mem_rdata;

    // Take a beat whenever the error core can make room for it
    assign accept = in_valid && !in_stall;

    // Track column, line end and first-line mask; hold line_width
    dith_ctrl #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .frame_start (frame_start),
        .col         (col),
        .ctl         (ctl)
    );

    // Error carried to the next line, one entry per column
    dith_line_mem #(
        .DEPTH(MAX_LINE_WIDTH),
        .DW   (AW)
    ) u_line_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (col),
        .rdata (mem_rdata)
    );

    // Quantize, diffuse, write back, drive the output register
    dith_core #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_col    (col),
        .in_level  (pixel_level),
        .in_ctl    (ctl),
        .in_stall  (in_stall),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .pixel_on  (pixel_on)
    );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for error_diffusion_dither: a directed table of pixels and width
// writes, then random pixel streams over many line widths, scored by a local predictor or typed-in values.
// Depends on dith_pkg and the rtl sources of the dither block.
module testbench;

    // Fixed-point view of the error core, at the block's default parameters
    localparam int FRAC       = 4;
    localparam int MAX_WIDTH  = 1024;
    localparam int ACC_MAX    = (1 << (FRAC + 11)) - 1;
    localparam int ACC_MIN    = -ACC_MAX - 1;
    localparam int FULL_WHITE = 255 << FRAC;
    localparam int HALF_SCALE = 255 << (FRAC - 1);

    localparam int RANDOM_PIXELS = 2000;
    localparam int SETTLE_CYCLES = 4;    // covers the output register plus the line-end trailing write
    localparam int MAX_PRINTED   = 100;

    // Pacing styles for each side of the block
    typedef enum int {PACE_FULL, PACE_BURSTY, PACE_RANDOM} pace_e;

    // One row of the directed table: a pixel beat or a line-width write
    typedef enum bit {ROW_PIXEL, ROW_WIDTH} row_kind_e;
    typedef struct packed {
        row_kind_e                    kind;
        logic [dith_pkg::CFG_W-1:0]   width;
        logic [dith_pkg::LEVEL_W-1:0] level;
        bit                           fs;
        bit                           known;   // expected pixel typed in below
        bit                           on;
    } dir_row_t;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           cfg_we      = 1'b0;
    logic [dith_pkg::CFG_W-1:0]     cfg_wdata   = '0;
    logic                           in_valid    = 1'b0;
    logic                           in_stall;
    logic [dith_pkg::LEVEL_W-1:0]   pixel_level = '0;
    logic                           frame_start = 1'b0;
    logic                           out_valid;
    logic                           out_stall   = 1'b0;
    logic                           pixel_on;

    // Predictor state: the diffusion buffers and the line position
    int                         err_below [MAX_WIDTH];
    bit                         col_written [MAX_WIDTH];
    int                         err_right   = 0;
    int                         err_pending = 0;
    int                         err_diag    = 0;
    int                         col         = 0;
    bit                         top_line    = 1'b1;
    logic [dith_pkg::CFG_W-1:0] width_shadow = dith_pkg::CFG_W'(dith_pkg::WIDTH_RESET);

    bit    pixel_on_q [$];     // expected dithered pixels, oldest first
    dir_row_t directed_rows [$];
    pace_e feed_pace  = PACE_FULL;
    pace_e drain_pace = PACE_FULL;
    int    mismatches   = 0;
    int    pixels_sent  = 0;
    int    pixels_seen  = 0;
    int    frames       = 0;
    int    width_writes = 0;

    error_diffusion_dither uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_level (pixel_level),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_on    (pixel_on)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Draw how many cycles one side holds off before its next beat
    function automatic int draw_wait(input pace_e pace);
        case (pace)
            PACE_FULL:   return 0;
            PACE_BURSTY: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
            default:     return $urandom_range(0, 18);
        endcase
    endfunction

    function automatic int clamp_acc(input int v);
        if (v > ACC_MAX)
            return ACC_MAX;
        if (v < ACC_MIN)
            return ACC_MIN;
        return v;
    endfunction

    // floor(e * k / 16): the arithmetic shift rounds toward minus infinity
    function automatic int share16(input int e, input int k);
        return (e * k) >>> 4;
    endfunction

    function automatic int width_eff();
        if (width_shadow == 0)
            return 1;
        if (width_shadow > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(width_shadow);
    endfunction

    // Dither one pixel: threshold the pixel plus diffused error, then spread the
    // quantization error right and onto the line below
    function automatic bit dither_pixel(input logic [dith_pkg::LEVEL_W-1:0] lvl, input bit fs);
        int  w;
        int  c;
        int  above;
        int  sum;
        int  e;
        bit  last;
        bit  white;
        w = width_eff();
        if (fs)
        begin
            col         = 0;
            err_right   = 0;
            err_pending = 0;
            err_diag    = 0;
            top_line    = 1'b1;
        end
        c     = col % MAX_WIDTH;
        last  = (c + 1 >= w);
        above = top_line ? 0 : err_below[c];
        sum   = clamp_acc((int'(lvl) << FRAC) + above + err_right);
        white = (sum > HALF_SCALE);
        e     = white ? sum - FULL_WHITE : sum;

        err_right = last ? 0 : clamp_acc(share16(e, 7));
        if (c > 0)
        begin
            err_below[c - 1]   = clamp_acc(err_pending + share16(e, 3));
            col_written[c - 1] = 1'b1;
        end
        err_pending = clamp_acc(err_diag + share16(e, 5));
        err_diag    = last ? 0 : share16(e, 1);

        if (last)
        begin
            // Close the line: flush the pending below share into this column
            err_below[c]   = err_pending;
            col_written[c] = 1'b1;
            err_pending    = 0;
            err_diag       = 0;
            col            = 0;
            top_line       = 1'b0;
        end
        else
            col = c + 1;
        return white;
    endfunction

    // The line buffer is never cleared, so a column that was never written must not be
    // read: restart the frame instead of reading such a column
    function automatic bit needs_restart(input bit fs);
        return !fs && !top_line && !col_written[col % MAX_WIDTH];
    endfunction

    function automatic logic [dith_pkg::LEVEL_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return dith_pkg::LEVEL_W'($urandom_range(120, 135));
            default: return dith_pkg::LEVEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic dir_row_t pix_row(input logic [dith_pkg::LEVEL_W-1:0] lvl, input bit fs,
                                         input bit known, input bit on);
        return '{kind: ROW_PIXEL, width: '0, level: lvl, fs: fs, known: known, on: on};
    endfunction

    function automatic dir_row_t width_row(input logic [dith_pkg::CFG_W-1:0] w);
        return '{kind: ROW_WIDTH, width: w, level: '0, fs: 1'b0, known: 1'b0, on: 1'b0};
    endfunction

    // Drive one pixel beat, hold it through any stall, and log its expected result.
    // Valid stays high on return so back-to-back beats need no extra assignment.
    task automatic send_pixel(input logic [dith_pkg::LEVEL_W-1:0] lvl, input bit fs,
                              input bit known, input bit typed_on);
        int gap;
        bit on;
        gap = draw_wait(feed_pace);
        if (needs_restart(fs))
            fs = 1'b1;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_level <= lvl;
        frame_start <= fs;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        on = dither_pixel(lvl, fs);
        pixel_on_q.push_back(known ? typed_on : on);
        pixels_sent++;
        if (fs)
            frames++;
    endtask

    // Write line_width only once the pipe has drained and the trailing write is done
    task automatic set_line_width(input logic [dith_pkg::CFG_W-1:0] w);
        in_valid <= 1'b0;
        while (pixel_on_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we       <= 1'b0;
        width_shadow = w;
        width_writes++;
    endtask

    // Output side: score each accepted beat, then hold stall for a drawn number of cycles
    initial
    begin : drain_results
        int hold;
        bit want;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall == 1'b0)
            begin
                pixels_seen++;
                if (pixel_on_q.size() == 0)
                    report_mismatch($sformatf("output beat with nothing expected, pixel_on=%b",
                                              pixel_on));
                else
                begin
                    want = pixel_on_q.pop_front();
                    if (pixel_on !== want)
                        report_mismatch($sformatf("beat %0d: pixel_on=%b, expected %b",
                                                  pixels_seen, pixel_on, want));
                end
                hold = draw_wait(drain_pace);
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : stimulus
        dir_row_t                   r;
        logic [dith_pkg::CFG_W-1:0] wsel;
        int                         w;
        int                         batch;
        int                         rand_count;
        bit                         fs;
        rand_count = 0;

        // Directed table. Expected pixels are typed in where the sum is obvious: a
        // frame start with no carried error, or an exact-zero error on the left.
        directed_rows.push_back(pix_row(8'd0,   1'b1, 1'b1, 1'b0));  // black extreme
        directed_rows.push_back(pix_row(8'd255, 1'b0, 1'b1, 1'b1));  // white extreme
        directed_rows.push_back(pix_row(8'd128, 1'b0, 1'b1, 1'b1));  // just over half scale
        directed_rows.push_back(pix_row(8'd127, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(pix_row(8'd255, 1'b1, 1'b1, 1'b1));  // frame start mid-line
        directed_rows.push_back(width_row(11'd0));                   // zero acts as one
        directed_rows.push_back(pix_row(8'd200, 1'b0, 1'b0, 1'b0));  // width shrunk mid-line
        directed_rows.push_back(pix_row(8'd0,   1'b0, 1'b0, 1'b0));
        directed_rows.push_back(pix_row(8'd255, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(width_row(11'h7FF));                 // clamps to the maximum
        directed_rows.push_back(pix_row(8'd0,   1'b1, 1'b1, 1'b0));
        directed_rows.push_back(pix_row(8'd255, 1'b0, 1'b1, 1'b1));
        directed_rows.push_back(pix_row(8'd17,  1'b0, 1'b0, 1'b0));
        directed_rows.push_back(pix_row(8'd240, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(width_row(11'd2));                   // two-pixel lines
        directed_rows.push_back(pix_row(8'd128, 1'b1, 1'b1, 1'b1));
        directed_rows.push_back(pix_row(8'd64,  1'b0, 1'b0, 1'b0));  // line end
        directed_rows.push_back(pix_row(8'd192, 1'b0, 1'b0, 1'b0));  // reads the buffer
        directed_rows.push_back(pix_row(8'd255, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(pix_row(8'd0,   1'b0, 1'b0, 1'b0));
        directed_rows.push_back(pix_row(8'd127, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(width_row(11'd3));                   // widen within a frame
        directed_rows.push_back(pix_row(8'd255, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(pix_row(8'd0,   1'b0, 1'b0, 1'b0));
        directed_rows.push_back(pix_row(8'd255, 1'b0, 1'b0, 1'b0));
        directed_rows.push_back(pix_row(8'd128, 1'b0, 1'b0, 1'b0));

        // Hold reset low, then release it on an edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the table with a random output side and a steady input side
        drain_pace = PACE_RANDOM;
        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            if (r.kind == ROW_WIDTH)
                set_line_width(r.width);
            else
                send_pixel(r.level, r.fs, r.known, r.on);
        end

        // Random phases: a width write, then a stream of pixels at fresh pacing.
        // Keep most widths small so lines wrap often and the buffer gets read.
        while (rand_count < RANDOM_PIXELS)
        begin
            case ($urandom_range(0, 15))
                0:       wsel = '0;
                1:       wsel = 11'd1;
                2:       wsel = '1;
                3:       wsel = dith_pkg::CFG_W'(MAX_WIDTH);
                4:       wsel = dith_pkg::CFG_W'($urandom_range(MAX_WIDTH + 1, 2046));
                5:       wsel = dith_pkg::CFG_W'(dith_pkg::WIDTH_RESET);
                6:       wsel = dith_pkg::CFG_W'($urandom_range(17, MAX_WIDTH - 1));
                default: wsel = dith_pkg::CFG_W'($urandom_range(2, 16));
            endcase
            set_line_width(wsel);
            feed_pace  = pace_e'($urandom_range(0, 2));
            drain_pace = pace_e'($urandom_range(0, 2));
            w = width_eff();
            if (w <= 16)
                batch = $urandom_range(1, 6 * w + 4);
            else if ($urandom_range(0, 3) == 0)
                batch = w + $urandom_range(1, 100);   // reach the second line
            else
                batch = $urandom_range(40, 200);
            for (int i = 0; i < batch; i++)
            begin
                if (i == 0)
                    fs = ($urandom_range(0, 2) == 0);
                else
                    fs = ($urandom_range(0, 199) == 0);
                send_pixel(pick_level(), fs, 1'b0, 1'b0);
                rand_count++;
            end
        end

        // Drop valid, drain, and give stray beats a chance to show up
        in_valid <= 1'b0;
        while (pixel_on_q.size() != 0)
            @(posedge clk);
        repeat (4 * SETTLE_CYCLES) @(posedge clk);

        $display("Dithered %0d pixels (%0d scored) across %0d frame starts,", pixels_sent,
                 pixels_seen, frames);
        $display("with %0d line-width writes from zero through the top of the register.",
                 width_writes);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Cap the run well past the slowest legal drain
    initial
    begin : watchdog
        #5_000_000;
        $display("timeout with %0d pixels still expected", pixel_on_q.size());
        $display("FAILURE");
        $finish;
    end

endmodule
